// ----- hw/rtl/hdc_pkg.sv -----
// Shared types and constants for the L2-L4 header drop classifier.
package hdc_pkg;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned HS_W   = 8;
    localparam int unsigned HL_W   = 6;
    localparam int unsigned PORT_W = 16;
    localparam int unsigned CFG_W  = 16;

    localparam logic [POS_W-1:0]  POS_MAX        = '1;
    localparam logic [PORT_W-1:0] TCP_PORT_RESET = 16'd80;
    localparam logic [PORT_W-1:0] UDP_PORT_RESET = 16'd9;

    localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ  = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;

    localparam logic [7:0] PROTO_IPIP = 8'd4;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_IPV6 = 8'd41;

    localparam logic [POS_W-1:0] OFF_ETYPE      = 16'd12;
    localparam logic [POS_W-1:0] OFF_VLAN_TYPE  = 16'd2;
    localparam logic [POS_W-1:0] OFF_V4_FRAG_HI = 16'd6;
    localparam logic [POS_W-1:0] OFF_V4_FRAG_LO = 16'd7;
    localparam logic [POS_W-1:0] OFF_V4_PROTO   = 16'd9;
    localparam logic [POS_W-1:0] OFF_V4_END     = 16'd19;
    localparam logic [POS_W-1:0] OFF_V6_NEXT    = 16'd6;
    localparam logic [POS_W-1:0] OFF_V6_END     = 16'd39;
    localparam logic [POS_W-1:0] OFF_SPORT_END  = 16'd2;
    localparam logic [POS_W-1:0] OFF_DPORT_END  = 16'd4;
    localparam logic [POS_W-1:0] OFF_TCP_END    = 16'd19;
    localparam logic [POS_W-1:0] OFF_UDP_END    = 16'd7;

    localparam logic [HL_W-1:0] V4_MIN_HL  = 6'd20;
    localparam logic [HS_W-1:0] V6_HDR_LEN = 8'd40;

    localparam logic [0:0] CFG_TCP_PORT = 1'b0;
    localparam logic [0:0] CFG_UDP_PORT = 1'b1;

    typedef enum logic [8:0] {
        PH_ETH    = 9'b000000001,
        PH_VLAN1  = 9'b000000010,
        PH_VLAN2  = 9'b000000100,
        PH_IPV4   = 9'b000001000,
        PH_INNER4 = 9'b000010000,
        PH_IPV6   = 9'b000100000,
        PH_INNER6 = 9'b001000000,
        PH_L4     = 9'b010000000,
        PH_DONE   = 9'b100000000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TCP  = 2'd1,
        KIND_UDP  = 2'd2
    } t_kind;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic [PORT_W-1:0] tcp_port;
        logic [PORT_W-1:0] udp_port;
    } t_drop_cfg;

endpackage

// ----- hw/rtl/hdc_parser.sv -----
// Per-packet header parse state and drop verdict logic, one byte per cycle.
module hdc_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hdc_pkg::t_byte_item i_item,
    input  hdc_pkg::t_drop_cfg  i_cfg,
    output logic               o_verdict
);
    import hdc_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    t_phase            r_phase, n_phase;
    logic [HS_W-1:0]   r_hs, n_hs;
    logic [15:0]       r_pw, n_pw;
    logic [HL_W-1:0]   r_hl, n_hl;
    t_kind             r_kind, n_kind;
    logic [PORT_W-1:0] r_sport, n_sport;
    logic [PORT_W-1:0] r_dport, n_dport;
    logic              r_done, n_done;

    logic [POS_W-1:0]  off;
    logic              in_hdr;
    logic              outer;
    logic [POS_W-1:0]  type_at;
    logic [15:0]       pw_shift;
    logic [HS_W-1:0]   ip_next;
    logic [7:0]        proto;
    logic [PORT_W-1:0] drop_port;

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_hs    = r_hs;
        n_pw    = r_pw;
        n_hl    = r_hl;
        n_kind  = r_kind;
        n_sport = r_sport;
        n_dport = r_dport;
        n_done  = r_done;

        in_hdr   = r_pos >= {{(POS_W-HS_W){1'b0}}, r_hs};
        off      = r_pos - {{(POS_W-HS_W){1'b0}}, r_hs};
        outer    = (r_phase == PH_IPV4) || (r_phase == PH_IPV6);
        type_at  = (r_phase == PH_ETH) ? OFF_ETYPE : OFF_VLAN_TYPE;
        pw_shift = {r_pw[7:0], i_item.data};
        proto    = r_pw[7:0];
        ip_next  = (r_phase == PH_IPV6 || r_phase == PH_INNER6) ?
                   r_hs + V6_HDR_LEN : r_hs + {{(HS_W-HL_W){1'b0}}, r_hl};

        if (i_item.valid && in_hdr) begin
            unique case (r_phase)
                PH_ETH, PH_VLAN1, PH_VLAN2: begin
                    if (off == type_at || off == type_at + 16'd1) begin
                        n_pw = pw_shift;
                    end
                    if (off == type_at + 16'd1) begin
                        n_hs = r_pos[HS_W-1:0] + 8'd1;
                        if (pw_shift == ETYPE_VLAN || pw_shift == ETYPE_QINQ) begin
                            n_phase = (r_phase == PH_ETH)   ? PH_VLAN1 :
                                      (r_phase == PH_VLAN1) ? PH_VLAN2 : PH_DONE;
                        end else if (pw_shift == ETYPE_IPV4) begin
                            n_phase = PH_IPV4;
                        end else if (pw_shift == ETYPE_IPV6) begin
                            n_phase = PH_IPV6;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_IPV4, PH_INNER4: begin
                    if (off == '0) begin
                        n_hl = {i_item.data[3:0], 2'b00};
                        if ({i_item.data[3:0], 2'b00} < V4_MIN_HL) begin
                            n_phase = PH_DONE;
                        end
                    end else if (off == OFF_V4_FRAG_HI) begin
                        if (outer && i_item.data[5:0] != '0) begin
                            n_phase = PH_DONE;
                        end
                    end else if (off == OFF_V4_FRAG_LO) begin
                        if (outer && i_item.data != '0) begin
                            n_phase = PH_DONE;
                        end
                    end else if (off == OFF_V4_PROTO) begin
                        n_pw = {8'd0, i_item.data};
                    end else if (off == OFF_V4_END) begin
                        n_hs = ip_next;
                        if (outer && proto == PROTO_IPIP) begin
                            n_phase = PH_INNER4;
                        end else if (proto == PROTO_TCP) begin
                            n_kind  = KIND_TCP;
                            n_phase = PH_L4;
                        end else if (proto == PROTO_UDP) begin
                            n_kind  = KIND_UDP;
                            n_phase = PH_L4;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_IPV6, PH_INNER6: begin
                    if (off == OFF_V6_NEXT) begin
                        n_pw = {8'd0, i_item.data};
                    end else if (off == OFF_V6_END) begin
                        n_hs = ip_next;
                        if (outer && proto == PROTO_IPIP) begin
                            n_phase = PH_INNER4;
                        end else if (outer && proto == PROTO_IPV6) begin
                            n_phase = PH_INNER6;
                        end else if (proto == PROTO_TCP) begin
                            n_kind  = KIND_TCP;
                            n_phase = PH_L4;
                        end else if (proto == PROTO_UDP) begin
                            n_kind  = KIND_UDP;
                            n_phase = PH_L4;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_L4: begin
                    if (off < OFF_SPORT_END) begin
                        n_sport = {r_sport[7:0], i_item.data};
                    end else if (off < OFF_DPORT_END) begin
                        n_dport = {r_dport[7:0], i_item.data};
                    end
                    if ((r_kind == KIND_TCP && off == OFF_TCP_END) ||
                        (r_kind == KIND_UDP && off == OFF_UDP_END)) begin
                        n_done  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        if (i_item.valid && r_pos != POS_MAX) begin
            n_pos = r_pos + 16'd1;
        end

        drop_port = (n_kind == KIND_TCP) ? i_cfg.tcp_port : i_cfg.udp_port;
        o_verdict = n_done && (n_kind != KIND_NONE) &&
                    (n_sport == drop_port || n_dport == drop_port);

        // end of frame: back to a clean per-packet state
        if (i_item.valid && i_item.last) begin
            n_pos   = '0;
            n_phase = PH_ETH;
            n_hs    = '0;
            n_pw    = '0;
            n_hl    = '0;
            n_kind  = KIND_NONE;
            n_sport = '0;
            n_dport = '0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_ETH;
            r_hs    <= '0;
            r_pw    <= '0;
            r_hl    <= '0;
            r_kind  <= KIND_NONE;
            r_sport <= '0;
            r_dport <= '0;
            r_done  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_hs    <= n_hs;
            r_pw    <= n_pw;
            r_hl    <= n_hl;
            r_kind  <= n_kind;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_done  <= n_done;
        end
    end

endmodule

// ----- hw/rtl/l2_l4_header_drop_classifier.sv -----
// Top level of the L2-L4 header drop classifier.
//
// Input channel: one frame byte per item (i_packet_byte, i_last_byte), taken
// when i_in_valid is high and o_in_stall is low. Frames start at the Ethernet
// destination address; i_last_byte marks the final byte.
// Output channel: one o_verdict item per frame (0 pass, 1 drop), offered on
// o_out_valid and taken when i_out_stall is low.
// Config: i_cfg_we writes i_cfg_wdata to the TCP (index 0) or UDP (index 1)
// drop port; write only while no frame is in flight.
// Throughput: one byte per cycle while the input is not stalled. Bytes pass an
// input register; the parser then updates its header state from it, and the
// verdict of a final byte lands in the output register at the same edge, so
// it is offered from the output register after the last byte is taken.
// Stall: a stalled verdict holds in the output register; only a final byte
// waiting behind it stalls the input, other bytes keep flowing.
// Reset: synchronous, active low; clears the pipeline and parse state and
// sets the drop ports to TCP 80 and UDP 9.
module l2_l4_header_drop_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_packet_byte,
    input  logic                      i_last_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_verdict,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [hdc_pkg::CFG_W-1:0] i_cfg_wdata
);
    import hdc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic       r_verdict;
    t_drop_cfg  r_cfg;

    logic       advance;
    logic       verdict;
    t_byte_item step;

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign step.valid = advance;
    assign step.data  = r_in_byte;
    assign step.last  = r_in_last;

    hdc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (step),
        .i_cfg     (r_cfg),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_packet_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= advance && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_verdict <= verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tcp_port <= TCP_PORT_RESET;
            r_cfg.udp_port <= UDP_PORT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TCP_PORT: r_cfg.tcp_port <= i_cfg_wdata;
                CFG_UDP_PORT: r_cfg.udp_port <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

endmodule

// ----- hw/rtl/hdc_checker.sv -----
// Port-level checks for the L2-L4 header drop classifier, bound to the top level.
module hdc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_verdict
);

    a_stalled_verdict_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) && $past(i_rst_n)
            |-> o_out_valid && $stable(o_verdict))
        else $error("stalled verdict changed or dropped");

    a_reset_clears_output: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

    a_stall_needs_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output can drain");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

endmodule

bind l2_l4_header_drop_classifier hdc_checker u_hdc_checker (.*);
